// File: rtl/mldp_pkg.sv
// Shared types, constants and the gamma table of the LED digit PWM scanner.
package mldp_pkg;

	localparam int unsigned DotBit = 8;
	localparam logic [5:0] PwmSteps = 6'd50;

	typedef enum logic [2:0] {
		OpTick       = 3'd0,
		OpSetBright  = 3'd1,
		OpSetPattern = 3'd2,
		OpSetDot     = 3'd3,
		OpClear      = 3'd4
	} mldp_op_t;

	// store write command
	typedef struct packed {
		logic        en;
		mldp_op_t    op;
		logic [1:0]  digit;
		logic [5:0]  level;
		logic [31:0] pattern;
		logic        dot;
	} mldp_wr_t;

	// gamma-corrected on-time, levels above full saturate
	function automatic logic [5:0] gamma_on_time(input logic [5:0] lvl);
		logic [5:0] t;
		case (lvl)
			6'd0, 6'd1, 6'd2, 6'd3, 6'd4,
			6'd5, 6'd6, 6'd7, 6'd8, 6'd9:    t = 6'd0;
			6'd10, 6'd11, 6'd12, 6'd13, 6'd14: t = 6'd1;
			6'd15, 6'd16:                  t = 6'd2;
			6'd17, 6'd18:                  t = 6'd3;
			6'd19, 6'd20:                  t = 6'd4;
			6'd21, 6'd22:                  t = 6'd5;
			6'd23:                         t = 6'd6;
			6'd24:                         t = 6'd7;
			6'd25, 6'd26:                  t = 6'd8;
			6'd27:                         t = 6'd9;
			6'd28:                         t = 6'd10;
			6'd29:                         t = 6'd12;
			6'd30:                         t = 6'd13;
			6'd31:                         t = 6'd14;
			6'd32:                         t = 6'd15;
			6'd33:                         t = 6'd17;
			6'd34:                         t = 6'd18;
			6'd35:                         t = 6'd19;
			6'd36:                         t = 6'd21;
			6'd37:                         t = 6'd23;
			6'd38:                         t = 6'd25;
			6'd39:                         t = 6'd26;
			6'd40:                         t = 6'd28;
			6'd41:                         t = 6'd30;
			6'd42:                         t = 6'd32;
			6'd43:                         t = 6'd35;
			6'd44:                         t = 6'd37;
			6'd45:                         t = 6'd39;
			6'd46:                         t = 6'd42;
			6'd47:                         t = 6'd44;
			6'd48:                         t = 6'd47;
			default:                       t = PwmSteps;
		endcase
		return t;
	endfunction

endpackage

// File: rtl/multiplexed_led_digit_pwm_scanner.sv
// Top level of the multiplexed LED digit scanner with per-digit PWM dimming.
//
// Input stream (s_*): one command item per handshake; tuser carries the opcode
// (tick, set brightness, set pattern, set dot, clear pattern), tdata the digit
// index, brightness level, segment pattern and dot flag.
// Output stream (m_*): exactly one item per command, giving the scan state
// after that command: active digit, anode enable and latched segment drive.
// From input handshake to output valid, an item passes the input register,
// then the state update and table lookup into the output register.
// Throughput is one item per cycle while the output is not stalled.
// The input register keeps taking items while a result waits in the output
// register; only when both are full and m_tready is low does s_tready drop.
// Reset clears the scan state and all patterns, and sets every digit to full
// brightness; no output item is pending after reset.
module multiplexed_led_digit_pwm_scanner
	import mldp_pkg::*;
#(
	parameter int DIGITS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // digit_index, brightness_level, segment_pattern_in, dot_on
	input  logic [2:0]  s_tuser,  // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // active_digit, anode_enable, segment_drive
);

	localparam int ScanW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

	logic             valid_s1;
	mldp_op_t         op_s1;
	logic [1:0]       digit_s1;
	logic [5:0]       level_s1;
	logic [31:0]      pattern_s1;
	logic             dot_s1;

	logic [5:0]       pwm_q;
	logic [ScanW-1:0] scan_q;
	logic [5:0]       on_time_q;
	logic [31:0]      latched_q;
	logic             anode_q;

	logic             out_valid_q;
	logic [1:0]       out_digit_q;
	logic             out_anode_q;
	logic [31:0]      out_seg_q;

	logic             advance;
	logic             step;
	logic             ok;
	mldp_wr_t         wr;
	logic [ScanW-1:0] scan_inc;
	logic [31:0]      rd_pattern;
	logic [5:0]       rd_level;
	logic [5:0]       cnt_inc;
	logic [5:0]       pwm_n;
	logic [ScanW-1:0] scan_n;
	logic [5:0]       on_time_n;
	logic [31:0]      latched_n;
	logic             anode_n;
	logic [3:0]       scan_wide;

	assign advance  = !out_valid_q || m_tready;
	assign step     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1      <= mldp_op_t'(s_tuser);
			digit_s1   <= s_tdata[1:0];
			level_s1   <= s_tdata[7:2];
			pattern_s1 <= s_tdata[39:8];
			dot_s1     <= s_tdata[40];
		end
	end

	assign ok = 4'(digit_s1) < 4'(DIGITS);

	always_comb begin
		wr.en      = step && ok && (op_s1 != OpTick);
		wr.op      = op_s1;
		wr.digit   = digit_s1;
		wr.level   = level_s1;
		wr.pattern = pattern_s1;
		wr.dot     = dot_s1;
	end

	assign scan_inc = (scan_q == ScanW'(DIGITS - 1)) ? '0 : scan_q + 1'b1;

	mldp_digit_store #(
		.DIGITS(DIGITS)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.rd_idx    (scan_inc),
		.rd_pattern(rd_pattern),
		.rd_level  (rd_level)
	);

	assign cnt_inc = pwm_q + 6'd1;

	always_comb begin
		pwm_n     = pwm_q;
		scan_n    = scan_q;
		on_time_n = on_time_q;
		latched_n = latched_q;
		anode_n   = anode_q;
		if (op_s1 == OpTick) begin
			pwm_n = cnt_inc;
			if (cnt_inc >= PwmSteps) begin
				scan_n    = scan_inc;
				on_time_n = gamma_on_time(rd_level);
				latched_n = rd_pattern;
				anode_n   = (rd_level != 6'd0);
				pwm_n     = '0;
			end
			if (pwm_n == on_time_n) begin
				anode_n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_q     <= '0;
			scan_q    <= '0;
			on_time_q <= '0;
			latched_q <= '0;
			anode_q   <= 1'b0;
		end else if (step) begin
			pwm_q     <= pwm_n;
			scan_q    <= scan_n;
			on_time_q <= on_time_n;
			latched_q <= latched_n;
			anode_q   <= anode_n;
		end
	end

	assign scan_wide = 4'(scan_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_digit_q <= scan_wide[1:0];
			out_anode_q <= anode_n;
			out_seg_q   <= latched_n;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_seg_q, out_anode_q, out_digit_q};

endmodule

// File: rtl/mldp_digit_store.sv
// Per-digit segment pattern and brightness registers with one scan read port.
module mldp_digit_store
	import mldp_pkg::*;
#(
	parameter int DIGITS = 4,
	localparam int ScanW = (DIGITS > 1) ? $clog2(DIGITS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mldp_wr_t         wr,
	input  logic [ScanW-1:0] rd_idx,
	output logic [31:0]      rd_pattern,
	output logic [5:0]       rd_level
);

	logic [31:0]      pattern_q [DIGITS];
	logic [5:0]       level_q   [DIGITS];
	logic [ScanW-1:0] wr_idx;
	logic [5:0]       level_sat;

	assign wr_idx    = ScanW'(wr.digit);
	assign level_sat = (wr.level > PwmSteps) ? PwmSteps : wr.level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGITS; i++) begin
				pattern_q[i] <= '0;
				level_q[i]   <= PwmSteps;
			end
		end else if (wr.en) begin
			case (wr.op)
				OpSetBright:  level_q[wr_idx] <= level_sat;
				OpSetPattern: pattern_q[wr_idx] <= wr.pattern;
				OpSetDot:     pattern_q[wr_idx][DotBit] <= wr.dot;
				OpClear:      pattern_q[wr_idx] <= '0;
				default:      ;
			endcase
		end
	end

	assign rd_pattern = pattern_q[rd_idx];
	assign rd_level   = level_q[rd_idx];

endmodule

// File: rtl/mldp_checker.sv
// Port-level checks of the LED digit scanner and their binding to the top level.
module mldp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	// output item held while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output item changed while stalled");

	// a rising output valid traces back to an item taken at the input
	a_rise_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result without matching input item");

	// an empty output register never blocks the input side
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// pad bits of the result stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:35] == 5'd0)
		else $error("result pad bits set");

endmodule

bind multiplexed_led_digit_pwm_scanner mldp_checker u_chk (.*);

// File: tb/sv/multiplexed_led_digit_pwm_scanner_tb.sv
// Self-checking testbench for the LED digit PWM scanner: streamed commands against a local model.
module multiplexed_led_digit_pwm_scanner_tb;
	import mldp_pkg::*;

	localparam int Digits    = 4;
	localparam int RandItems = 1800;
	localparam int CalmItems = 200;
	localparam int MaxReport = 10;

	localparam logic [5:0] GammaLut [0:50] = '{
		6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
		6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd2, 6'd2, 6'd3, 6'd3, 6'd4,
		6'd4, 6'd5, 6'd5, 6'd6, 6'd7, 6'd8, 6'd8, 6'd9, 6'd10, 6'd12,
		6'd13, 6'd14, 6'd15, 6'd17, 6'd18, 6'd19, 6'd21, 6'd23, 6'd25, 6'd26,
		6'd28, 6'd30, 6'd32, 6'd35, 6'd37, 6'd39, 6'd42, 6'd44, 6'd47, 6'd50,
		6'd50
	};

	typedef struct packed {
		logic [2:0]  op;
		logic [1:0]  digit;
		logic [5:0]  level;
		logic [31:0] pattern;
		logic        dot;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  digit;
		logic        anode;
		logic [31:0] seg;
	} scan_out_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	multiplexed_led_digit_pwm_scanner #(
		.DIGITS(Digits)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// model state
	logic [31:0] pat_mem [Digits];
	logic [5:0]  lvl_mem [Digits];
	logic [5:0]  pwm_cnt;
	logic [1:0]  scan_pos;
	logic [5:0]  on_cnt;
	logic [31:0] held_pat;
	logic        anode_on;

	cmd_t      cmd_backlog [$];
	scan_out_t scan_due [$];
	cmd_t      cur_cmd;
	cmd_t      nxt_cmd;
	scan_out_t want;
	scan_out_t got;
	int        send_gap;
	int        stall_left;
	int        mismatch_cnt = 0;
	logic      calm = 1'b0;

	assign got = '{digit: m_tdata[1:0], anode: m_tdata[2], seg: m_tdata[34:3]};

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic scan_out_t scan_predict(input cmd_t c);
		logic [5:0] lv;
		scan_out_t  r;
		lv = (c.level > PwmSteps) ? PwmSteps : c.level;
		case (c.op)
			OpTick: begin
				pwm_cnt = pwm_cnt + 6'd1;
				if (pwm_cnt >= PwmSteps) begin
					scan_pos = (scan_pos == Digits - 1) ? 2'd0 : scan_pos + 2'd1;
					on_cnt   = GammaLut[lvl_mem[scan_pos]];
					held_pat = pat_mem[scan_pos];
					anode_on = (lvl_mem[scan_pos] != 6'd0);
					pwm_cnt  = 6'd0;
				end
				if (pwm_cnt == on_cnt)
					anode_on = 1'b0;
			end
			OpSetBright:  lvl_mem[c.digit] = lv;
			OpSetPattern: pat_mem[c.digit] = c.pattern;
			OpSetDot:     pat_mem[c.digit][DotBit] = c.dot;
			OpClear:      pat_mem[c.digit] = 32'd0;
			default: ;
		endcase
		r = '{digit: scan_pos, anode: anode_on, seg: held_pat};
		return r;
	endfunction

	task automatic push_cmd(input logic [2:0] op, input logic [1:0] d, input logic [5:0] lv,
			input logic [31:0] pat, input logic dot);
		cmd_backlog.push_back('{op: op, digit: d, level: lv, pattern: pat, dot: dot});
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
			send_gap <= 0;
			calm     <= 1'b0;
			for (int i = 0; i < Digits; i++) begin
				pat_mem[i] = 32'd0;
				lvl_mem[i] = PwmSteps;
			end
			pwm_cnt  = 6'd0;
			scan_pos = 2'd0;
			on_cnt   = 6'd0;
			held_pat = 32'd0;
			anode_on = 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				scan_due.push_back(scan_predict(cur_cmd));
			calm <= (cmd_backlog.size() < CalmItems);
			if (s_tvalid && !s_tready) begin
				// item still waiting, hold it
			end else if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				s_tvalid <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				send_gap <= $urandom_range(0, 7);
				s_tvalid <= 1'b0;
			end else if (cmd_backlog.size() != 0) begin
				nxt_cmd  = cmd_backlog.pop_front();
				cur_cmd  <= nxt_cmd;
				s_tvalid <= 1'b1;
				s_tdata  <= {7'd0, nxt_cmd.dot, nxt_cmd.pattern, nxt_cmd.level, nxt_cmd.digit};
				s_tuser  <= nxt_cmd.op;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (scan_due.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= MaxReport)
						$display("unexpected item: digit %0d anode %0d seg %h",
							got.digit, got.anode, got.seg);
				end else begin
					want = scan_due.pop_front();
					if (got.digit !== want.digit || got.anode !== want.anode ||
							got.seg !== want.seg) begin
						mismatch_cnt++;
						if (mismatch_cnt <= MaxReport)
							$display("mismatch: exp digit %0d anode %0d seg %h, got digit %0d anode %0d seg %h",
								want.digit, want.anode, want.seg,
								got.digit, got.anode, got.seg);
					end
				end
			end
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				m_tready   <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_left <= $urandom_range(0, 7);
				m_tready   <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// stimulus and end of run
	initial begin
		logic [2:0]  op;
		logic [5:0]  lv;
		int          r;
		arst_n = 1'b0;

		// directed: level extremes, saturation, low levels, pattern halves, dot, unused opcodes
		push_cmd(OpSetBright, 2'd0, 6'd50, 32'h0, 1'b0);
		push_cmd(OpSetBright, 2'd1, 6'd0, 32'h0, 1'b0);
		push_cmd(OpSetBright, 2'd2, 6'd63, 32'h0, 1'b0);
		push_cmd(OpSetBright, 2'd3, 6'd5, 32'h0, 1'b0);
		push_cmd(OpSetPattern, 2'd0, 6'd0, 32'hFFFF_FFFF, 1'b1);
		push_cmd(OpSetPattern, 2'd1, 6'd63, 32'h0000_FFFF, 1'b0);
		push_cmd(OpSetPattern, 2'd2, 6'd0, 32'hFFFF_0000, 1'b1);
		push_cmd(OpSetPattern, 2'd3, 6'd0, 32'h0, 1'b0);
		push_cmd(OpSetDot, 2'd3, 6'd0, 32'h0, 1'b1);
		push_cmd(OpSetDot, 2'd0, 6'd0, 32'hFFFF_FFFF, 1'b0);
		push_cmd(OpSetDot, 2'd2, 6'd0, 32'h0, 1'b1);
		push_cmd(OpClear, 2'd2, 6'd0, 32'hFFFF_FFFF, 1'b1);
		push_cmd(OpSetPattern, 2'd2, 6'd0, 32'hA5A5_5A5A, 1'b0);
		push_cmd(3'd5, 2'd1, 6'd63, 32'hFFFF_FFFF, 1'b1);
		push_cmd(3'd6, 2'd3, 6'd50, 32'h1234_5678, 1'b0);
		push_cmd(3'd7, 2'd2, 6'd0, 32'h0, 1'b1);
		push_cmd(OpTick, 2'd3, 6'd63, 32'hFFFF_FFFF, 1'b1);
		push_cmd(OpTick, 2'd0, 6'd0, 32'h0, 1'b0);
		push_cmd(OpSetBright, 2'd1, 6'd10, 32'h0, 1'b0);
		push_cmd(OpSetBright, 2'd0, 6'd51, 32'h0, 1'b0);
		push_cmd(OpTick, 2'd1, 6'd1, 32'h0, 1'b0);

		// random: mostly ticks so the scan runs through many slots
		for (int n = 0; n < RandItems; n++) begin
			r = $urandom_range(0, 99);
			if (r < 84)
				op = OpTick;
			else if (r < 90)
				op = OpSetBright;
			else if (r < 94)
				op = OpSetPattern;
			else if (r < 97)
				op = OpSetDot;
			else if (r < 99)
				op = OpClear;
			else
				op = 3'($urandom_range(5, 7));
			case ($urandom_range(0, 7))
				0:       lv = 6'd0;
				1:       lv = 6'd50;
				2:       lv = 6'($urandom_range(51, 63));
				3:       lv = 6'($urandom_range(1, 9));
				default: lv = 6'($urandom_range(0, 50));
			endcase
			push_cmd(op, 2'($urandom_range(0, 3)), lv, $urandom, 1'($urandom_range(0, 1)));
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (cmd_backlog.size() != 0 || s_tvalid)
			@(posedge clk);
		while (scan_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

endmodule
